### hw/rtl/signed_integer_radix_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer radix formatter
// Concurrent checks are compiled in unless SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_RADIX_FORMATTER_ASSERT_SVH
`define SIGNED_INTEGER_RADIX_FORMATTER_ASSERT_SVH

`ifndef SYNTH
// prop must hold on every clock edge outside reset
`define SIRF_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// cond must never be true outside reset
`define SIRF_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SIRF_ASSERT(name, clk, rst, prop)
`define SIRF_NEVER(name, clk, rst, cond)
`endif

`endif

### hw/rtl/sirf_pkg.sv
// ----------------------------------------------------------------------------
// sirf_pkg
// Shared constants, register indexes and controller/datapath link types.
// ----------------------------------------------------------------------------
package sirf_pkg;

  localparam int MAX_BASE      = 16;
  localparam int LEN_W         = 5;
  localparam int DIGIT_W       = $clog2(MAX_BASE);
  localparam int SYM_W         = 8;
  localparam int ALPHA_SYMS    = 16;
  localparam int MAG_W         = 32;
  localparam int STACK_DEPTH   = MAG_W;
  localparam int COUNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = MAG_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 64;

  localparam logic [SYM_W-1:0] SYM_PLUS    = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS   = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_LOWEST  = 8'd33;
  localparam logic [SYM_W-1:0] SYM_HIGHEST = 8'd126;
  localparam logic [LEN_W-1:0] MIN_RADIX   = 5'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX_LEN  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIVIDE = 4'b0010,
    ST_SIGN   = 4'b0100,
    ST_EMIT   = 4'b1000
  } sirf_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic load_sign;
    logic pop;
  } sirf_cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic step_last;
    logic quot_zero;
    logic last_digit;
  } sirf_status_t;

endpackage

### hw/rtl/sirf_ctrl.sv
// ----------------------------------------------------------------------------
// sirf_ctrl
// Sequencer: accept, per-digit division passes, sign, digit emission.
// ----------------------------------------------------------------------------
`include "signed_integer_radix_formatter_assert.svh"

module sirf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  output logic                  char_valid,
  input  logic                  char_stall,
  output logic                  cfg_ready,
  input  sirf_pkg::sirf_status_t sts,
  output sirf_pkg::sirf_cmd_t   cmd
);
  import sirf_pkg::*;

  sirf_state_t state;
  sirf_state_t state_next;
  logic        char_valid_next;
  logic        out_free;
  logic        accept;

  assign item_stall = (state != ST_IDLE);
  assign cfg_ready  = (state == ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);
  assign out_free   = !char_valid || !char_stall;

  always_comb begin
    cmd.load      = accept;
    cmd.div_step  = (state == ST_DIVIDE);
    cmd.load_sign = (state == ST_SIGN) && out_free;
    cmd.pop       = (state == ST_EMIT) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && sts.alpha_ok) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (sts.step_last && sts.quot_zero) state_next = sts.neg ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (out_free) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && sts.last_digit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign char_valid_next = (cmd.load_sign || cmd.pop) ? 1'b1 : (char_valid && char_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
    end else begin
      state      <= state_next;
      char_valid <= char_valid_next;
    end
  end

  `SIRF_ASSERT(a_div_holds, clk, rst, (state == ST_DIVIDE && !sts.step_last) |=> (state == ST_DIVIDE))
  `SIRF_ASSERT(a_sign_only_neg, clk, rst, (state == ST_SIGN) |-> sts.neg)
  `SIRF_ASSERT(a_valid_alpha_starts, clk, rst, (cmd.load && sts.alpha_ok) |=> (state == ST_DIVIDE))
  `SIRF_NEVER(a_no_load_while_busy, clk, rst, cmd.load && (cmd.pop || cmd.load_sign || cmd.div_step))

endmodule

### hw/rtl/sirf_dp.sv
// ----------------------------------------------------------------------------
// sirf_dp
// Config registers, alphabet check, byte-serial divider, digit stack and
// output character register.
// ----------------------------------------------------------------------------
`include "signed_integer_radix_formatter_assert.svh"

module sirf_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic signed [sirf_pkg::MAG_W-1:0] number,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [sirf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sirf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  sirf_pkg::sirf_cmd_t              cmd,
  output sirf_pkg::sirf_status_t           sts,
  output logic [sirf_pkg::SYM_W-1:0]       symbol,
  output logic                             final_char
);
  import sirf_pkg::*;

  logic [CFG_DATA_W-1:0]                  alphabet_low;
  logic [CFG_DATA_W-1:0]                  alphabet_high;
  logic [LEN_W-1:0]                       radix_length;
  logic [ALPHA_SYMS-1:0][SYM_W-1:0]       alpha_all;
  logic [MAX_BASE-1:0][SYM_W-1:0]         sym;
  logic                                   alpha_ok;

  logic [MAG_W-1:0]                       mag;
  logic [MAG_W-1:0]                       raw;
  logic [MAG_W-1:0]                       quot_next;
  logic [DIGIT_W-1:0]                     rem;
  logic [DIGIT_W-1:0]                     rem_next;
  logic [BITS_PER_STEP-1:0]               qbits;
  logic [STEP_W-1:0]                      step;
  logic                                   neg;
  logic [STACK_DEPTH-1:0][DIGIT_W-1:0]    stack;
  logic [COUNT_W-1:0]                     count;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_low  <= '0;
      alphabet_high <= '0;
      radix_length  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ALPHA_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHA_HIGH: alphabet_high <= cfg_data;
        REG_RADIX_LEN:  radix_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign alpha_all = {alphabet_high, alphabet_low};
  assign sym       = alpha_all[MAX_BASE-1:0];

  always_comb begin
    alpha_ok = (radix_length >= MIN_RADIX) && (radix_length <= LEN_W'(MAX_BASE));
    for (int i = 0; i < MAX_BASE; i++) begin
      if (LEN_W'(i) < radix_length) begin
        if (sym[i] < SYM_LOWEST || sym[i] > SYM_HIGHEST ||
            sym[i] == SYM_PLUS || sym[i] == SYM_MINUS) alpha_ok = 1'b0;
        for (int j = i + 1; j < MAX_BASE; j++) begin
          if (LEN_W'(j) < radix_length && sym[j] == sym[i]) alpha_ok = 1'b0;
        end
      end
    end
  end

  // one quotient byte per cycle, restoring division by the radix
  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [LEN_W-1:0]   t;
    r     = (step == '0) ? '0 : rem;
    qbits = '0;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      t = LEN_W'({r, mag[MAG_W-1-b]});
      if (t >= radix_length) begin
        t = t - radix_length;
        qbits[BITS_PER_STEP-1-b] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next  = r;
    quot_next = {mag[MAG_W-BITS_PER_STEP-1:0], qbits};
  end

  assign raw = number;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg <= raw[MAG_W-1];
      mag <= raw[MAG_W-1] ? (~raw + 1'b1) : raw;
    end else if (cmd.div_step) begin
      mag <= quot_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      count <= '0;
    end else if (cmd.load) begin
      step  <= '0;
      count <= '0;
    end else begin
      if (cmd.div_step) step <= step + 1'b1;
      if (cmd.div_step && sts.step_last) count <= count + 1'b1;
      else if (cmd.pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && sts.step_last) begin
      stack <= {stack[STACK_DEPTH-2:0], rem_next};
    end else if (cmd.pop) begin
      stack <= {DIGIT_W'(0), stack[STACK_DEPTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sign) begin
      symbol     <= SYM_MINUS;
      final_char <= 1'b0;
    end else if (cmd.pop) begin
      symbol     <= sym[stack[0]];
      final_char <= (count == COUNT_W'(1));
    end
  end

  always_comb begin
    sts.alpha_ok   = alpha_ok;
    sts.neg        = neg;
    sts.step_last  = (step == STEP_W'(DIV_STEPS - 1));
    sts.quot_zero  = (quot_next == '0);
    sts.last_digit = (count == COUNT_W'(1));
  end

  `SIRF_ASSERT(a_count_range, clk, rst, count <= COUNT_W'(STACK_DEPTH))
  `SIRF_NEVER(a_pop_empty, clk, rst, cmd.pop && (count == '0))
  `SIRF_ASSERT(a_rem_below_radix, clk, rst, (cmd.div_step && step != '0) |-> (LEN_W'(rem) < radix_length))
  `SIRF_ASSERT(a_digit_below_radix, clk, rst, cmd.pop |-> (LEN_W'(stack[0]) < radix_length))

endmodule

### hw/rtl/signed_integer_radix_formatter.sv
// ----------------------------------------------------------------------------
// signed_integer_radix_formatter
// Writes a signed 32-bit number as text in a configured radix, one character
// per output transaction, most significant digit first.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------
//   item     | item_valid / item_stall | number[31:0] signed
//   char     | char_valid / char_stall | symbol[7:0], final_char
//   cfg      | cfg_valid / cfg_ready   | cfg_index[1:0], cfg_data[63:0]
//
// One number at a time: after the accept, each digit is found by a divider
// pass over the magnitude (8 quotient bits per cycle), then the sign, if
// negative, and the digits are emitted.
// Reset (rst, synchronous) clears the config registers to 0, which is an
// invalid alphabet: numbers are then taken and dropped without output.
// char_stall holds the output register and the sign and emit steps; the divider does not wait on it.
// ----------------------------------------------------------------------------
module signed_integer_radix_formatter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic signed [sirf_pkg::MAG_W-1:0] number,
  output logic                              char_valid,
  input  logic                              char_stall,
  output logic [sirf_pkg::SYM_W-1:0]        symbol,
  output logic                              final_char,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sirf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sirf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sirf_pkg::*;

  sirf_cmd_t    cmd;
  sirf_status_t sts;

  sirf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .cfg_ready  (cfg_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sirf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .number     (number),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .symbol     (symbol),
    .final_char (final_char)
  );

endmodule

### bench/tb_signed_integer_radix_formatter.sv
// ----------------------------------------------------------------------------
// tb_signed_integer_radix_formatter
// Self-checking bench for the radix formatter. A directed table covers reset,
// the extremes of the number, alphabet faults and unused symbol slots. Random
// phases follow, each with its own alphabet and radix. Every character is
// compared with an in-bench prediction while the sender and receiver throttle
// at random.
// ----------------------------------------------------------------------------
module tb_signed_integer_radix_formatter;
  import sirf_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES  = 250;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 200;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } char_t;

  typedef enum {ROW_WRITE, ROW_NUMBER} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [MAG_W-1:0]      value;
    bit                    typed;
    string                 text;
  } row_t;

  typedef enum {
    FAULT_NONE, FAULT_REPEAT, FAULT_PLUS, FAULT_MINUS,
    FAULT_LOW_CODE, FAULT_HIGH_CODE, FAULT_RADIX
  } alpha_fault_t;

  typedef enum {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_BUSY} stall_mode_t;

  logic                    clk;
  logic                    rst;
  logic                    item_valid;
  logic                    item_stall;
  logic signed [MAG_W-1:0] number;
  logic                    char_valid;
  logic                    char_stall;
  logic [SYM_W-1:0]        symbol;
  logic                    final_char;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  logic [CFG_DATA_W-1:0] alpha_low_cfg;
  logic [CFG_DATA_W-1:0] alpha_high_cfg;
  logic [LEN_W-1:0]      radix_cfg;

  char_t pending_text[$];
  row_t  directed_rows[$];
  char_t want;

  int error_count;
  int numbers_sent;
  int numbers_dropped;
  int chars_checked;
  int radix_writes;
  int numbers_since_drain;
  int burst_left;
  int idle_gap;
  int hold_requests;
  int holds_started;
  int hold_left;
  int mode_left;
  int idle_cycles;
  bit valid_held;
  bit cfg_held;
  stall_mode_t stall_mode;

  signed_integer_radix_formatter uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .number     (number),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .symbol     (symbol),
    .final_char (final_char),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [SYM_W-1:0] symbol_at(int pos);
    if (pos < 8) return alpha_low_cfg[pos*8 +: 8];
    return alpha_high_cfg[(pos-8)*8 +: 8];
  endfunction

  function automatic bit alphabet_valid();
    logic [SYM_W-1:0] s;
    if (radix_cfg < MIN_RADIX || radix_cfg > MAX_BASE) return 1'b0;
    for (int i = 0; i < radix_cfg; i++) begin
      s = symbol_at(i);
      if (s < SYM_LOWEST || s > SYM_HIGHEST || s == SYM_PLUS || s == SYM_MINUS)
        return 1'b0;
      for (int j = i + 1; j < radix_cfg; j++)
        if (symbol_at(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void format_number(logic [MAG_W-1:0] value);
    logic [MAG_W-1:0]   mag;
    logic [DIGIT_W-1:0] digits [STACK_DEPTH];
    int nd;
    if (!alphabet_valid()) return;
    mag = value[MAG_W-1] ? -value : value;
    nd = 0;
    do begin
      digits[nd] = DIGIT_W'(mag % radix_cfg);
      nd++;
      mag = mag / radix_cfg;
    end while (mag != 0);
    if (value[MAG_W-1]) pending_text.push_back('{sym: SYM_MINUS, last: 1'b0});
    for (int k = nd - 1; k >= 0; k--)
      pending_text.push_back('{sym: symbol_at(digits[k]), last: (k == 0)});
  endfunction

  function automatic void flag_error(string what, logic [63:0] exp_val,
                                     logic [63:0] got_val);
    error_count++;
    if (error_count <= 10)
      $display("ERROR %s: expected %0h, got %0h at %0t", what, exp_val, got_val, $time);
  endfunction

  function automatic logic [127:0] pack_symbols(string s);
    logic [127:0] bytes = '0;
    for (int i = 0; i < s.len() && i < ALPHA_SYMS; i++) bytes[i*8 +: 8] = s[i];
    return bytes;
  endfunction

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    row_t r;
    r.kind = ROW_WRITE;
    r.index = idx;
    r.data = data;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_alphabet(string s);
    logic [127:0] bytes;
    bytes = pack_symbols(s);
    add_write(REG_ALPHA_LOW, bytes[63:0]);
    add_write(REG_ALPHA_HIGH, bytes[127:64]);
  endfunction

  function automatic void add_number(logic [MAG_W-1:0] value, bit typed, string text);
    row_t r;
    r.kind = ROW_NUMBER;
    r.value = value;
    r.typed = typed;
    r.text = text;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [127:0] random_alphabet(int len, alpha_fault_t fault);
    logic [127:0]     bytes;
    logic [SYM_W-1:0] s;
    bit               taken [256];
    int               pos;
    int               other;
    for (int i = 0; i < ALPHA_SYMS; i++) bytes[i*8 +: 8] = SYM_W'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      do s = SYM_W'($urandom_range(SYM_LOWEST, SYM_HIGHEST));
      while (taken[s] || s == SYM_PLUS || s == SYM_MINUS);
      taken[s] = 1'b1;
      bytes[i*8 +: 8] = s;
    end
    pos = $urandom_range(0, len - 1);
    other = (pos + $urandom_range(1, len - 1)) % len;
    case (fault)
      FAULT_REPEAT:    bytes[pos*8 +: 8] = bytes[other*8 +: 8];
      FAULT_PLUS:      bytes[pos*8 +: 8] = SYM_PLUS;
      FAULT_MINUS:     bytes[pos*8 +: 8] = SYM_MINUS;
      FAULT_LOW_CODE:  bytes[pos*8 +: 8] = SYM_W'($urandom_range(0, SYM_LOWEST - 1));
      FAULT_HIGH_CODE: bytes[pos*8 +: 8] = SYM_W'($urandom_range(SYM_HIGHEST + 1, 255));
      default: ;
    endcase
    return bytes;
  endfunction

  function automatic logic [MAG_W-1:0] random_number(int radix);
    logic [MAG_W-1:0] v;
    case ($urandom_range(0, 6))
      0: v = $urandom;
      1: v = $urandom_range(0, radix * radix);
      2: v = -$urandom_range(1, radix * radix * radix);
      3: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = 32'd1;
          2: v = '1;
          3: v = 32'h8000_0000;
          4: v = 32'h7FFF_FFFF;
          default: v = 32'h8000_0001;
        endcase
      end
      4: begin
        v = 32'd1;
        repeat ($urandom_range(0, 31)) v = v * radix;
        if ($urandom_range(0, 1)) v = v - 1;
        if ($urandom_range(0, 2) == 0) v = -v;
      end
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // waits out the last text and any number still being dropped
  task automatic settle();
    if (valid_held) begin
      item_valid <= 1'b0;
      valid_held = 1'b0;
    end
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held = 1'b0;
    end
    while (pending_text.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    numbers_since_drain = 0;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (numbers_since_drain != 0) settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_held = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ALPHA_LOW:  alpha_low_cfg = data;
      REG_ALPHA_HIGH: alpha_high_cfg = data;
      REG_RADIX_LEN: begin
        radix_cfg = data[LEN_W-1:0];
        radix_writes++;
      end
      default: ;
    endcase
  endtask

  task automatic send_number(logic [MAG_W-1:0] value, bit typed, string text);
    if (cfg_held) begin
      cfg_valid <= 1'b0;
      cfg_held = 1'b0;
    end
    if (!valid_held) begin
      repeat (idle_gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    item_valid <= 1'b1;
    number <= value;
    valid_held = 1'b1;
    do @(posedge clk); while (item_stall);
    numbers_sent++;
    numbers_since_drain++;
    if (!alphabet_valid()) numbers_dropped++;
    if (typed) begin
      for (int i = 0; i < text.len(); i++)
        pending_text.push_back('{sym: text[i], last: (i == text.len() - 1)});
    end else begin
      format_number(value);
    end
    burst_left--;
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      valid_held = 1'b0;
      idle_gap = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
    end
  endtask

  // receiver throttle, with a long hold on request
  always @(posedge clk) begin
    if (holds_started != hold_requests) begin
      holds_started++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      char_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 80);
      end
      mode_left--;
      case (stall_mode)
        RX_FREE:     char_stall <= 1'b0;
        RX_RANDOM:   char_stall <= ($urandom_range(0, 9) < 3);
        RX_PERIODIC: char_stall <= (mode_left % 3 == 0);
        default:     char_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // character check and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && !char_stall) begin
        if (pending_text.size() == 0) begin
          flag_error("unexpected character", 64'd0, 64'({final_char, symbol}));
        end else begin
          want = pending_text.pop_front();
          chars_checked++;
          if (symbol !== want.sym) flag_error("symbol", 64'(want.sym), 64'(symbol));
          if (final_char !== want.last)
            flag_error("final_char", 64'(want.last), 64'(final_char));
        end
      end
      if ((item_valid && !item_stall) || (char_valid && !char_stall) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int syms;
    int count;
    int random_sent;
    alpha_fault_t fault;
    logic [127:0] alpha;
    logic [CFG_DATA_W-1:0] radix_word;

    rst = 1'b1;
    item_valid = 1'b0;
    number = '0;
    char_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    alpha_low_cfg = '0;
    alpha_high_cfg = '0;
    radix_cfg = '0;

    // after reset the alphabet is empty
    add_number(32'd5, 1, "");
    add_number(32'hFFFF_FFFF, 1, "");
    add_write(REG_UNUSED, '1);
    add_alphabet("0123456789ABCDEF");
    add_write(REG_RADIX_LEN, 64'hFFFF_FFFF_FFFF_FFEA);
    add_number(32'd0, 1, "0");
    add_number(32'h7FFF_FFFF, 1, "2147483647");
    add_number(32'h8000_0000, 1, "-2147483648");
    add_number(32'hFFFF_FFFF, 1, "-1");
    add_number(32'd10, 1, "10");
    add_write(REG_RADIX_LEN, 64'd16);
    add_number(32'h8000_0000, 1, "-80000000");
    add_number(32'h7FFF_FFFF, 1, "7FFFFFFF");
    add_number(32'd48879, 1, "BEEF");
    add_write(REG_RADIX_LEN, 64'd2);
    add_number(32'h8000_0000, 1, "-10000000000000000000000000000000");
    add_number(32'h7FFF_FFFF, 0, "");
    add_write(REG_RADIX_LEN, 64'd1);
    add_number(32'd7, 1, "");
    add_write(REG_RADIX_LEN, 64'd17);
    add_number(32'd7, 1, "");
    add_write(REG_RADIX_LEN, 64'hA5A5_0000_0000_003F);
    add_number(32'd7, 1, "");
    add_alphabet("0123456789ABCDE0");
    add_write(REG_RADIX_LEN, 64'd16);
    add_number(32'd12345, 1, "");
    add_write(REG_RADIX_LEN, 64'd15);
    add_number(32'd15, 1, "10");
    add_number(-32'sd123456789, 0, "");
    add_alphabet("012-");
    add_write(REG_RADIX_LEN, 64'd4);
    add_number(32'd5, 1, "");
    add_write(REG_RADIX_LEN, 64'd3);
    add_number(32'd5, 1, "12");
    add_alphabet("01+");
    add_number(32'd5, 1, "");
    add_alphabet("!~");
    add_write(REG_RADIX_LEN, 64'd2);
    add_number(32'd2, 1, "~!");
    add_alphabet(" 1");
    add_number(32'd1, 1, "");
    add_alphabet("0\177");
    add_number(32'd1, 1, "");
    add_alphabet("0120");
    add_write(REG_RADIX_LEN, 64'd4);
    add_number(32'd1, 1, "");

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE)
        write_register(directed_rows[i].index, directed_rows[i].data);
      else
        send_number(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].text);
    end

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      phase++;
      fault = ($urandom_range(0, 9) < 7) ? FAULT_NONE : alpha_fault_t'($urandom_range(1, 6));
      case ($urandom_range(0, 3))
        0: syms = 2;
        1: syms = MAX_BASE;
        default: syms = $urandom_range(2, MAX_BASE);
      endcase
      if (phase == 3) begin
        fault = FAULT_NONE;
        syms = 2;
      end
      alpha = random_alphabet(syms, fault);
      radix_word = {$urandom, $urandom};
      radix_word[LEN_W-1:0] = LEN_W'(syms);
      if (fault == FAULT_RADIX)
        radix_word[LEN_W-1:0] = LEN_W'($urandom_range(0, 1) ? $urandom_range(0, 1) :
                                                              $urandom_range(MAX_BASE + 1, 31));
      if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, {$urandom, $urandom});
      write_register(REG_ALPHA_LOW, alpha[63:0]);
      write_register(REG_ALPHA_HIGH, alpha[127:64]);
      write_register(REG_RADIX_LEN, radix_word);
      if (phase == 3) hold_requests++;
      count = (fault == FAULT_NONE) ? $urandom_range(8, 30) : $urandom_range(3, 8);
      repeat (count) begin
        send_number(random_number(syms), 0, "");
        if (alphabet_valid()) random_sent++;
      end
    end

    settle();
    $display("Sent %0d numbers (%0d dropped on a bad alphabet), %0d radix settings,",
             numbers_sent, numbers_dropped, radix_writes);
    $display("checked %0d characters over %0d random phases, %0d errors.",
             chars_checked, phase, error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/sirf_pkg.sv
hw/rtl/sirf_ctrl.sv
hw/rtl/sirf_dp.sv
hw/rtl/signed_integer_radix_formatter.sv
bench/tb_signed_integer_radix_formatter.sv
